FILE: rtl/core/htsc_pkg.sv
// Shared constants, types and codes of the hit time slewing correction core.
// Used by the core module and htsc_horner; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package htsc_pkg;

    // Table sizes
    localparam int NUM_CHANNELS = 4096;
    localparam int SLEW_TERMS   = 6;

    // Field widths
    localparam int CH_W      = 12;
    localparam int SEL_W     = 3;
    localparam int LOAD_W    = 48;
    localparam int RAW_W     = 35;
    localparam int TOT_W     = 22;
    localparam int DELAY_W   = 11;
    localparam int OUT_W     = 36;
    localparam int BW_W      = 16;
    localparam int WIN_W     = 28;
    localparam int ACC_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // Window in 1/16 ns to 1/16 ps
    localparam int WINDOW_SCALE = 1000;
    localparam int WINSC_W      = WIN_W + 10;

    // Memory addressing
    localparam int WIN_AW     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int COEF_DEPTH = NUM_CHANNELS * SLEW_TERMS;
    localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int KW         = (SLEW_TERMS > 1) ? $clog2(SLEW_TERMS) : 1;
    localparam int K_TOP      = (SLEW_TERMS > 1) ? SLEW_TERMS - 2 : 0;

    // Horner datapath widths
    localparam int HALF_W    = ACC_W / 2;
    localparam int PP_W      = HALF_W + TOT_W;
    localparam int PROD_W    = ACC_W + TOT_W;
    localparam int RND_SHIFT = 16;
    localparam int TERM_W    = PROD_W - RND_SHIFT + 1;
    localparam int ADD_W     = TERM_W + 1;
    localparam int OUT_SHIFT = 20;
    localparam int POUT_W    = ACC_W - OUT_SHIFT + 2;

    // Final time sum widths
    localparam int DBW_W = DELAY_W + BW_W;
    localparam int SUM_W = 42;

    // Opcodes and word selects
    localparam logic             OP_CALIBRATE = 1'b0;
    localparam logic             OP_LOAD      = 1'b1;
    localparam logic [SEL_W-1:0] SEL_WINDOW   = '0;

    // Register reset values
    localparam logic [BW_W-1:0]  BUNCH_WIDTH_RST = 16'd390;
    localparam logic [TOT_W-1:0] TOT_MIN_RST     = '0;
    localparam logic [TOT_W-1:0] TOT_MAX_RST     = '1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CTP_LATENCY = 3'd0,
        CFG_TIME_ZERO   = 3'd1,
        CFG_BUNCH_WIDTH = 3'd2,
        CFG_TOT_MIN     = 3'd3,
        CFG_TOT_MAX     = 3'd4
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_TOP,
        S_MAG,
        S_MUL_LO,
        S_MUL_HI,
        S_RND,
        S_ADD,
        S_OMAG,
        S_ORND,
        S_SUM
    } state_t;

    // Datapath step strobes from the sequencer
    typedef struct packed {
        logic load_top;
        logic mag;
        logic mul_lo;
        logic mul_hi;
        logic rnd;
        logic add;
        logic out_rnd;
    } dp_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/hit_time_slewing_correction_core.sv
// Hit time slewing correction core: sequencer, channel tables, time sum.
// Depends on htsc_pkg, htsc_ram and htsc_horner.
//
// Usage:
//   The s_ channel takes one word per item. A load word (s_opcode = 1)
//   writes the channel's latency window or one slewing coefficient; loads
//   may follow each other in every cycle while the core is idle and give no
//   result. A calibrate word (s_opcode = 0) gives one m_corrected_time word.
//   A calibrate holds s_ready low until its result is taken into the output
//   register: m_valid rises and s_ready returns at the same edge. The
//   sequence is set by the Horner loop: each of the SLEW_TERMS-1 steps
//   runs on the one shared 24x22 multiplier (magnitude, two partial
//   products, rounding, coefficient add with clamp).
//   The result sits in an output register; with m_ready low the core still
//   takes loads and the next calibrate, and holds in its final sum step
//   until that register frees.
//   The cfg_ channel is always ready; write its registers only while the
//   core is idle, which the core itself does not enforce. Reset (aresetn
//   low, synchronous) sets the registers to their defaults and empties the
//   output; the tables keep no reset value and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none

module hit_time_slewing_correction_core import htsc_pkg::*; (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_opcode,
    input  wire logic        [CH_W-1:0]     s_channel,
    input  wire logic        [SEL_W-1:0]    s_word_select,
    input  wire logic signed [LOAD_W-1:0]   s_load_value,
    input  wire logic        [RAW_W-1:0]    s_raw_time,
    input  wire logic        [TOT_W-1:0]    s_tot,
    input  wire logic signed [DELAY_W-1:0]  s_trigger_delay,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed      [OUT_W-1:0]    m_corrected_time,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [CFG_W-1:0]    cfg_data
);

    // Configuration registers
    logic signed [CFG_W-1:0] ctp_reg;
    logic signed [CFG_W-1:0] tz_reg;
    logic        [BW_W-1:0]  bw_reg;
    logic        [TOT_W-1:0] tot_min_reg;
    logic        [TOT_W-1:0] tot_max_reg;

    // Sequencer
    state_t              state_reg;
    state_t              state_next;
    logic   [KW-1:0]     k_reg;
    logic   [KW-1:0]     k_next;
    logic   [KW-1:0]     k_rd;
    dp_ctrl_t            ctrl;
    logic                coef_re;
    logic                out_load;

    // Item registers
    logic                       ch_valid_reg;
    logic        [COEF_AW-1:0]  coef_base_reg;
    logic        [TOT_W-1:0]    tot_reg;
    logic        [RAW_W-1:0]    raw_reg;
    logic signed [DBW_W-1:0]    dbw_reg;
    logic signed [SUM_W-1:0]    base_reg;
    logic        [WINSC_W-1:0]  win_sc_reg;

    // Output register
    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  out_data_reg;
    logic signed [OUT_W-1:0]  out_data_next;

    // Input decode
    logic                     accept;
    logic                     is_load;
    logic                     ch_ok;
    logic                     sel_coef;
    logic                     win_we;
    logic                     coef_we;
    logic                     win_re;
    logic        [COEF_AW-1:0] in_base;
    logic        [COEF_AW-1:0] coef_addr;
    logic        [TOT_W-1:0]  tot_lo;
    logic        [TOT_W-1:0]  tot_clamp;

    // Memory and datapath links
    logic        [WIN_W-1:0]   win_rdata;
    logic        [ACC_W-1:0]   coef_rdata;
    logic signed [POUT_W-1:0]  pout;
    logic signed [SUM_W-1:0]   fin_sum;
    logic                      out_free;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign is_load   = (s_opcode == OP_LOAD);
    assign ch_ok     = (int'(s_channel) < NUM_CHANNELS);
    assign sel_coef  = (s_word_select != SEL_WINDOW) && (int'(s_word_select) <= SLEW_TERMS);
    assign win_we    = accept && is_load && ch_ok && (s_word_select == SEL_WINDOW);
    assign coef_we   = accept && is_load && ch_ok && sel_coef;
    assign win_re    = accept && !is_load;
    assign in_base   = COEF_AW'(int'(s_channel) * SLEW_TERMS);
    assign out_free  = !out_valid_reg || m_ready;

    // Coefficient address: port word for a load and top term for a calibrate while idle, else running term index
    always_comb begin
        if (state_reg == S_IDLE) begin
            if (is_load) begin
                coef_addr = in_base + COEF_AW'(s_word_select - SEL_W'(1));
            end else begin
                coef_addr = in_base + COEF_AW'(SLEW_TERMS - 1);
            end
        end else begin
            coef_addr = coef_base_reg + COEF_AW'(k_rd);
        end
    end

    // Clamp tot: lower bound first, upper bound second
    assign tot_lo    = (s_tot < tot_min_reg) ? tot_min_reg : s_tot;
    assign tot_clamp = (tot_lo > tot_max_reg) ? tot_max_reg : tot_lo;

    // Channel tables
    htsc_ram #(
        .WIDTH (WIN_W),
        .DEPTH (NUM_CHANNELS)
    ) u_win_ram (
        .aclk  (aclk),
        .we    (win_we),
        .re    (win_re),
        .addr  (WIN_AW'(s_channel)),
        .wdata (s_load_value[WIN_W-1:0]),
        .rdata (win_rdata)
    );

    htsc_ram #(
        .WIDTH (ACC_W),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .re    (coef_re),
        .addr  (coef_addr),
        .wdata (s_load_value),
        .rdata (coef_rdata)
    );

    // Shared multiplier datapath
    htsc_horner u_horner (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .coef_valid (ch_valid_reg),
        .coef       ($signed(coef_rdata)),
        .tot        (tot_reg),
        .pout       (pout)
    );

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctp_reg     <= '0;
            tz_reg      <= '0;
            bw_reg      <= BUNCH_WIDTH_RST;
            tot_min_reg <= TOT_MIN_RST;
            tot_max_reg <= TOT_MAX_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_CTP_LATENCY: ctp_reg     <= $signed(cfg_data);
                CFG_TIME_ZERO:   tz_reg      <= $signed(cfg_data);
                CFG_BUNCH_WIDTH: bw_reg      <= cfg_data[BW_W-1:0];
                CFG_TOT_MIN:     tot_min_reg <= cfg_data[TOT_W-1:0];
                CFG_TOT_MAX:     tot_max_reg <= cfg_data[TOT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && !is_load) begin
                    state_next = S_TOP;
                end
            end
            S_TOP:    state_next = (SLEW_TERMS > 1) ? S_MAG : S_OMAG;
            S_MAG:    state_next = S_MUL_LO;
            S_MUL_LO: state_next = S_MUL_HI;
            S_MUL_HI: state_next = S_RND;
            S_RND:    state_next = S_ADD;
            S_ADD:    state_next = (k_reg == '0) ? S_OMAG : S_MAG;
            S_OMAG:   state_next = S_ORND;
            S_ORND:   state_next = S_SUM;
            S_SUM: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        ctrl     = '0;
        coef_re  = 1'b0;
        k_rd     = k_reg;
        k_next   = k_reg;
        out_load = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                coef_re = accept && !is_load;
            end
            S_TOP: begin
                ctrl.load_top = 1'b1;
                coef_re       = (SLEW_TERMS > 1);
                k_rd          = KW'(K_TOP);
                k_next        = KW'(K_TOP);
            end
            S_MAG:    ctrl.mag    = 1'b1;
            S_MUL_LO: ctrl.mul_lo = 1'b1;
            S_MUL_HI: ctrl.mul_hi = 1'b1;
            S_RND:    ctrl.rnd    = 1'b1;
            S_ADD: begin
                ctrl.add = 1'b1;
                if (k_reg != '0) begin
                    coef_re = 1'b1;
                    k_rd    = k_reg - KW'(1);
                    k_next  = k_reg - KW'(1);
                end
            end
            S_OMAG:   ctrl.mag     = 1'b1;
            S_ORND:   ctrl.out_rnd = 1'b1;
            S_SUM:    out_load     = out_free;
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Latch the calibrate word, form the fixed part of the sum and load the output register
    always_ff @(posedge aclk) begin
        if (accept && !is_load) begin
            ch_valid_reg  <= ch_ok;
            coef_base_reg <= in_base;
            tot_reg       <= tot_clamp;
            raw_reg       <= s_raw_time;
            dbw_reg       <= DBW_W'(s_trigger_delay) * DBW_W'($signed({1'b0, bw_reg}));
        end
        if (state_reg == S_TOP) begin
            base_reg   <= SUM_W'($signed({1'b0, raw_reg})) + SUM_W'(dbw_reg)
                        + SUM_W'(ctp_reg) - SUM_W'(tz_reg);
            win_sc_reg <= ch_valid_reg ? WINSC_W'(win_rdata) * WINSC_W'(WINDOW_SCALE) : '0;
        end
        if (out_load) begin
            out_data_reg <= out_data_next;
        end
    end

    // Final sum and clamp to the output range
    assign fin_sum = base_reg - SUM_W'($signed({1'b0, win_sc_reg})) - SUM_W'(pout);
    always_comb begin
        if ((&fin_sum[SUM_W-1:OUT_W-1]) || !(|fin_sum[SUM_W-1:OUT_W-1])) begin
            out_data_next = fin_sum[OUT_W-1:0];
        end else if (fin_sum[SUM_W-1]) begin
            out_data_next = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            out_data_next = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_corrected_time = out_data_reg;

    // A calibrate word starts the sequence at once
    a_cal_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_load) |=> (state_reg == S_TOP))
        else $error("calibrate word did not start the sequence");

    // A load word leaves the sequencer idle
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_load) |=> (state_reg == S_IDLE))
        else $error("load word moved the sequencer");

    // Tables change only while idle
    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (win_we || coef_we) |-> (state_reg == S_IDLE))
        else $error("table write outside idle");

    // A new result comes only from the final sum step
    a_out_from_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == S_SUM))
        else $error("result raised outside final sum");

    // The term index stays within the coefficient set
    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ADD) |-> (int'(k_reg) <= K_TOP))
        else $error("term index out of range");

endmodule

`default_nettype wire

FILE: rtl/core/htsc_ram.sv
// Generic single-port RAM with registered read data.
// Holds the channel tables; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module htsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                          wdata,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read; read data holds while re is low
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/htsc_horner.sv
// Shared multiplier datapath: Horner steps of the slewing polynomial and the
// final rounding to output units. Depends on htsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module htsc_horner import htsc_pkg::*; (
    input  wire logic                     aclk,
    input  wire dp_ctrl_t                 ctrl,
    input  wire logic                     coef_valid,
    input  wire logic signed [ACC_W-1:0]  coef,
    input  wire logic        [TOT_W-1:0]  tot,
    output logic signed      [POUT_W-1:0] pout
);

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     neg_reg;
    logic        [ACC_W-1:0]  mag_reg;
    logic        [PROD_W-1:0] prod_reg;
    logic        [PROD_W-1:0] prod_next;
    logic signed [TERM_W-1:0] term_reg;
    logic signed [TERM_W-1:0] term_next;
    logic signed [POUT_W-1:0] pout_reg;
    logic signed [POUT_W-1:0] pout_next;

    logic signed [ACC_W-1:0]  coef_eff;
    logic        [HALF_W-1:0] mul_a;
    logic        [PP_W-1:0]   pp;
    logic        [PROD_W-1:0] rnd_sum;
    logic        [PROD_W-1:0] rnd_mag;
    logic signed [TERM_W-1:0] term_pos;
    logic signed [ADD_W-1:0]  add_sum;
    logic        [ACC_W:0]    out_sum;
    logic        [ACC_W:0]    out_mag;
    logic signed [POUT_W-1:0] out_pos;

    // Unknown channels read as all-zero coefficients
    assign coef_eff = coef_valid ? coef : '0;

    // One multiplier, half of the magnitude per cycle
    assign mul_a = ctrl.mul_hi ? mag_reg[ACC_W-1:HALF_W] : mag_reg[HALF_W-1:0];
    assign pp    = PP_W'(mul_a) * PP_W'(tot);

    always_comb begin
        if (ctrl.mul_hi) begin
            prod_next = prod_reg + (PROD_W'(pp) << HALF_W);
        end else begin
            prod_next = PROD_W'(pp);
        end
    end

    // Round magnitude by 2^16, ties away from zero, then restore sign
    assign rnd_sum  = prod_reg + (PROD_W'(1) << (RND_SHIFT - 1));
    assign rnd_mag  = rnd_sum >> RND_SHIFT;
    assign term_pos = $signed({1'b0, rnd_mag[TERM_W-2:0]});
    assign term_next = neg_reg ? -term_pos : term_pos;

    // Add coefficient and clamp to the accumulator range
    assign add_sum = ADD_W'(term_reg) + ADD_W'(coef_eff);
    always_comb begin
        if ((&add_sum[ADD_W-1:ACC_W-1]) || !(|add_sum[ADD_W-1:ACC_W-1])) begin
            acc_next = add_sum[ACC_W-1:0];
        end else if (add_sum[ADD_W-1]) begin
            acc_next = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            acc_next = {1'b0, {(ACC_W-1){1'b1}}};
        end
    end

    // Round polynomial by 2^20 to output units, ties away from zero
    assign out_sum   = {1'b0, mag_reg} + ((ACC_W + 1)'(1) << (OUT_SHIFT - 1));
    assign out_mag   = out_sum >> OUT_SHIFT;
    assign out_pos   = $signed({1'b0, out_mag[POUT_W-2:0]});
    assign pout_next = neg_reg ? -out_pos : out_pos;

    // Step registers, each advanced by its own strobe
    always_ff @(posedge aclk) begin
        if (ctrl.load_top) begin
            acc_reg <= coef_eff;
        end else if (ctrl.add) begin
            acc_reg <= acc_next;
        end
        if (ctrl.mag) begin
            neg_reg <= acc_reg[ACC_W-1];
            mag_reg <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        end
        if (ctrl.mul_lo || ctrl.mul_hi) begin
            prod_reg <= prod_next;
        end
        if (ctrl.rnd) begin
            term_reg <= term_next;
        end
        if (ctrl.out_rnd) begin
            pout_reg <= pout_next;
        end
    end

    assign pout = pout_reg;

endmodule

`default_nettype wire
